FILE: rtl/core/qts_pkg.sv
// shared types, constants and the split table for the quad triangulation split
// no dependencies
package qts_pkg;

  localparam int unsigned NUM_CASES = 11;
  localparam int unsigned CASE_W    = 4;
  localparam int unsigned TOL_W     = 32;

  typedef logic [1:0]        corner_t;
  typedef logic [CASE_W-1:0] case_t;

  localparam case_t CASE_C012_E2_SHORT = 4'd0;
  localparam case_t CASE_C013_E3_SHORT = 4'd3;
  localparam case_t CASE_C023_E3_SHORT = 4'd6;
  localparam case_t CASE_DIAG_13       = 4'd9;
  localparam case_t CASE_DIAG_02       = 4'd10;

  typedef struct packed {
    corner_t a_first;
    corner_t a_second;
    corner_t a_third;
    corner_t b_first;
    corner_t b_second;
    corner_t b_third;
  } tri_pair_t;

  // collinear result of one corner triple
  typedef struct packed {
    logic  hit;
    case_t sel;
  } coll_t;

  function automatic tri_pair_t split_lookup(input case_t sc);
    tri_pair_t r;
    unique case (sc)
      4'd0:    r = '{2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd3};
      4'd1:    r = '{2'd0, 2'd1, 2'd3, 2'd1, 2'd2, 2'd3};
      4'd2:    r = '{2'd2, 2'd0, 2'd3, 2'd0, 2'd1, 2'd3};
      4'd3:    r = '{2'd0, 2'd3, 2'd2, 2'd3, 2'd1, 2'd2};
      4'd4:    r = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd3, 2'd2};
      4'd5:    r = '{2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2};
      4'd6:    r = '{2'd0, 2'd1, 2'd3, 2'd1, 2'd2, 2'd3};
      4'd7:    r = '{2'd0, 2'd2, 2'd1, 2'd2, 2'd3, 2'd1};
      4'd8:    r = '{2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1};
      4'd9:    r = '{2'd0, 2'd1, 2'd3, 2'd1, 2'd2, 2'd3};
      default: r = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/qts_edge_cross.sv
// stages 1-3: edges, cross product terms, cross products and edge dots/lengths
// no dependencies
module qts_edge_cross #(
  parameter int unsigned CW = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] p [4][3],
  output logic signed [2*CW+2:0] cr [3][3],   // c12, c13, c23
  output logic signed [2*CW+3:0] dt [3],      // e1.e2, e1.e3, e2.e3
  output logic signed [2*CW+3:0] ln [3]       // e1.e1, e2.e2, e3.e3
);
  localparam int unsigned EW = CW + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned CRW = PW + 1;
  localparam int unsigned DW = PW + 2;

  logic signed [EW-1:0] e [3][3];
  logic signed [PW-1:0] pa [3][3];
  logic signed [PW-1:0] pb [3][3];
  logic signed [PW-1:0] dp [3][3];
  logic signed [PW-1:0] lp [3][3];

  // edge pairs for cross: (e1,e2) (e1,e3) (e2,e3)
  localparam int A_IDX [3] = '{0, 0, 1};
  localparam int B_IDX [3] = '{1, 2, 2};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          e[i][k] <= EW'(p[i+1][k]) - EW'(p[0][k]);
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pa[j][k] <= e[A_IDX[j]][(k+1)%3] * e[B_IDX[j]][(k+2)%3];
          pb[j][k] <= e[A_IDX[j]][(k+2)%3] * e[B_IDX[j]][(k+1)%3];
          dp[j][k] <= e[A_IDX[j]][k] * e[B_IDX[j]][k];
          lp[j][k] <= e[j][k] * e[j][k];
        end
      end
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++)
          cr[j][k] <= CRW'(pa[j][k]) - CRW'(pb[j][k]);
        dt[j] <= DW'(dp[j][0]) + DW'(dp[j][1]) + DW'(dp[j][2]);
        ln[j] <= DW'(lp[j][0]) + DW'(lp[j][1]) + DW'(lp[j][2]);
      end
    end
  end
endmodule

FILE: rtl/core/qts_decide.sv
// stages 4-6: squared cross lengths, c12.c23 products, branch choice
// depends on qts_pkg
module qts_decide #(
  parameter int unsigned CW = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [qts_pkg::TOL_W-1:0] tol,
  input  logic signed [2*CW+2:0] cr [3][3],
  input  logic signed [2*CW+3:0] dt [3],
  input  logic signed [2*CW+3:0] ln [3],
  output qts_pkg::case_t         sc
);
  localparam int unsigned CRW = 2 * CW + 3;
  localparam int unsigned LW = 18;
  localparam int unsigned HPW = CRW + (CRW - LW);
  localparam int unsigned LPW = CRW + LW + 1;
  localparam int unsigned HSW = HPW + 2;
  localparam int unsigned LSW = LPW + 2;
  localparam int unsigned SW = HSW + LW + 1;

  logic [2:0]            big;
  logic [31:0]           sq [3][3];
  logic signed [HPW-1:0] ph [3];
  logic signed [LPW-1:0] pl [3];
  logic signed [HSW-1:0] hs;
  logic signed [LSW-1:0] ls;
  logic signed [SW-1:0]  dsum;
  qts_pkg::coll_t        cl [3];
  qts_pkg::coll_t        cl2 [3];
  logic [2:0]            blw;
  logic                  neg;

  function automatic qts_pkg::coll_t coll_pick(input logic signed [2*CW+3:0] d,
      input logic signed [2*CW+3:0] la, input logic signed [2*CW+3:0] lb,
      input qts_pkg::case_t base);
    qts_pkg::coll_t r;
    r.hit = 1'b0;
    if (d > 0) begin
      if (lb < la) r.sel = base;
      else         r.sel = base + 4'd1;
    end else begin
      r.sel = base + 4'd2;
    end
    return r;
  endfunction

  // lower 16 bits of a cross component magnitude, squared
  function automatic logic [31:0] sq16(input logic signed [CRW-1:0] v);
    logic [CRW-1:0] m;
    m = v[CRW-1] ? CRW'(-v) : CRW'(v);
    return m[15:0] * m[15:0];
  endfunction

  function automatic logic is_big(input logic signed [CRW-1:0] v);
    logic [CRW-1:0] m;
    m = v[CRW-1] ? CRW'(-v) : CRW'(v);
    return |m[CRW-1:16];
  endfunction

  // stage 4: per-component squares, c12.c23 partial products, collinear selections
  // c23 components are cut into a signed high slice and an 18-bit low slice
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        big[j] <= is_big(cr[j][0]) | is_big(cr[j][1]) | is_big(cr[j][2]);
        for (int k = 0; k < 3; k++) sq[j][k] <= sq16(cr[j][k]);
        ph[j] <= cr[0][j] * $signed(cr[2][j][CRW-1:LW]);
        pl[j] <= cr[0][j] * $signed({1'b0, cr[2][j][LW-1:0]});
      end
      cl[0] <= coll_pick(dt[0], ln[0], ln[1], qts_pkg::CASE_C012_E2_SHORT);
      cl[1] <= coll_pick(dt[1], ln[0], ln[2], qts_pkg::CASE_C013_E3_SHORT);
      cl[2] <= coll_pick(dt[2], ln[1], ln[2], qts_pkg::CASE_C023_E3_SHORT);
    end
  end

  // stage 5: length sums against tolerance, partial sums of c12.c23
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++)
        blw[j] <= !big[j] && ((34'(sq[j][0]) + 34'(sq[j][1]) + 34'(sq[j][2]))
                              < 34'(tol));
      hs <= HSW'(ph[0]) + HSW'(ph[1]) + HSW'(ph[2]);
      ls <= LSW'(pl[0]) + LSW'(pl[1]) + LSW'(pl[2]);
      cl2 <= cl;
    end
  end

  // sign of c12.c23 from the two partial sums
  always_comb begin
    dsum = (SW'(hs) <<< LW) + SW'(ls);
    neg = dsum[SW-1];
  end

  // stage 6: branch priority
  always_ff @(posedge clk) begin
    if (en) begin
      priority if (blw[0]) sc <= cl2[0].sel;
      else if (blw[1])     sc <= cl2[1].sel;
      else if (blw[2])     sc <= cl2[2].sel;
      else if (neg)        sc <= qts_pkg::CASE_DIAG_13;
      else                 sc <= qts_pkg::CASE_DIAG_02;
    end
  end
endmodule

FILE: rtl/core/quad_triangulation_split.sv
// quad triangulation split: one word per cycle while not stalled, through a 7-stage
// pipeline from input word to output register that moves as one on stall
// rst (synchronous) clears all valid bits and sets collinear_tolerance to 1
module quad_triangulation_split #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [COORD_WIDTH-1:0] c0_x, c0_y, c0_z,
  input  logic signed [COORD_WIDTH-1:0] c1_x, c1_y, c1_z,
  input  logic signed [COORD_WIDTH-1:0] c2_x, c2_y, c2_z,
  input  logic signed [COORD_WIDTH-1:0] c3_x, c3_y, c3_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  tri_a_first,
  output logic [1:0]  tri_a_second,
  output logic [1:0]  tri_a_third,
  output logic [1:0]  tri_b_first,
  output logic [1:0]  tri_b_second,
  output logic [1:0]  tri_b_third,
  output logic [3:0]  split_case
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DEPTH = 6;

  logic [31:0]           collinear_tolerance;
  logic [DEPTH-1:0]      vld;
  logic                  en;
  logic signed [CW-1:0]  p [4][3];
  logic signed [2*CW+2:0] cr [3][3];
  logic signed [2*CW+3:0] dt [3];
  logic signed [2*CW+3:0] ln [3];
  qts_pkg::case_t        sc;
  qts_pkg::tri_pair_t    tp;

  // whole pipeline advances unless a finished word is held at the output
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    p[0][0] = c0_x; p[0][1] = c0_y; p[0][2] = c0_z;
    p[1][0] = c1_x; p[1][1] = c1_y; p[1][2] = c1_z;
    p[2][0] = c2_x; p[2][1] = c2_y; p[2][2] = c2_z;
    p[3][0] = c3_x; p[3][1] = c3_y; p[3][2] = c3_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collinear_tolerance <= 32'd1;
      vld <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) collinear_tolerance <= cfg_wdata;
      if (en) begin
        vld <= {vld[DEPTH-2:0], in_valid};
        out_valid <= vld[DEPTH-1];
      end
    end
  end

  qts_edge_cross #(.CW(CW)) u_edge (
    .clk(clk), .en(en), .p(p), .cr(cr), .dt(dt), .ln(ln)
  );

  qts_decide #(.CW(CW)) u_dec (
    .clk(clk), .en(en), .tol(collinear_tolerance),
    .cr(cr), .dt(dt), .ln(ln), .sc(sc)
  );

  assign tp = qts_pkg::split_lookup(sc);

  always_ff @(posedge clk) begin
    if (en) begin
      tri_a_first  <= tp.a_first;
      tri_a_second <= tp.a_second;
      tri_a_third  <= tp.a_third;
      tri_b_first  <= tp.b_first;
      tri_b_second <= tp.b_second;
      tri_b_third  <= tp.b_third;
      split_case   <= sc;
    end
  end
endmodule

FILE: rtl/core/qts_checker.sv
// port-level checks for the quad triangulation split
// bound to quad_triangulation_split
module qts_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] tri_a_first,
  input logic [1:0] tri_a_second,
  input logic [1:0] tri_a_third,
  input logic [3:0] split_case
);
  a_case_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> split_case <= 4'd10) else $error("split case out of range");

  a_tri_distinct: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tri_a_first != tri_a_second) && (tri_a_first != tri_a_third)
                  && (tri_a_second != tri_a_third)) else $error("repeated corner");

  a_stall_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall) else $error("input taken while output held");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(split_case))
    else $error("held word changed");
endmodule

bind quad_triangulation_split qts_checker u_qts_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .tri_a_first(tri_a_first), .tri_a_second(tri_a_second),
  .tri_a_third(tri_a_third), .split_case(split_case)
);
